// File: sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: field widths,
// operation and character codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 64;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_COLOR   = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // cell value after reset: space in attribute 0x07
  localparam logic [15:0] CELL_RESET = 16'h0720;

  localparam logic [6:0] COLUMNS_RESET = 7'd80;
  localparam logic [4:0] ROWS_RESET    = 5'd25;
  localparam logic [7:0] COLOR_RESET   = 8'd7;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_BS_WR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_BL,
    ST_CLR,
    ST_RD,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    WR_CHAR,
    WR_BLANK_CUR,
    WR_BLANK_IDX,
    WR_COPY,
    WR_INIT
  } wr_sel_e;

  typedef enum logic {
    RD_CELL,
    RD_SCROLL
  } rd_sel_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_NEXTROW,
    CUR_SCROLL,
    CUR_HOME,
    CUR_INC,
    CUR_BACK
  } cur_op_e;

  typedef enum logic [1:0] {
    K_PRINT,
    K_NEWLINE,
    K_IGNORE,
    K_BACKSPACE
  } ch_kind_e;

  typedef struct packed {
    logic    start;
    logic    idx_clr;
    logic    idx_inc;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    rd_en;
    rd_sel_e rd_sel;
    cur_op_e cur_op;
    logic    put_dec;
    logic    cell_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic     wrap;
    logic     last_row;
    logic     col_zero;
    logic     row_zero;
    ch_kind_e kind;
    logic     put_more;
    logic     copy_done;
    logic     sweep_last;
    logic     init_last;
    logic     rd_in_range;
    logic     out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, scroll count, sweep index and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int unsigned MAX_COLS = 80,
  parameter int unsigned MAX_ROWS = 25
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tcw_pkg::InDataW-1:0]   in_data_i,
  input  wire logic [6:0]                    columns_i,
  input  wire logic [4:0]                    rows_i,
  input  wire logic [7:0]                    color_i,
  input  wire tcw_pkg::cmd_t                 cmd_i,
  output tcw_pkg::sts_t                      sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [tcw_pkg::OutDataW-1:0]       out_data_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned SW    = ((AW > 12) ? AW : 12) + 1;

  logic [15:0]   mem_q [CELLS];
  logic [15:0]   rdata_q;

  logic [6:0]    ncols_q;
  logic [4:0]    nrows_q;
  logic [11:0]   cells_q;
  logic [7:0]    ch_q;
  logic [6:0]    rc_q;
  logic [4:0]    rr_q;
  logic [1:0]    put_left_q;
  logic [6:0]    cur_col_q, cur_col_d;
  logic [4:0]    cur_row_q, cur_row_d;
  logic [31:0]   scroll_q, scroll_d;
  logic [AW-1:0] idx_q;
  logic [15:0]   cell_q;
  logic          out_valid_q;
  logic [59:0]   out_q;

  logic [6:0]    ncols_eff;
  logic [4:0]    nrows_eff;
  logic [11:0]   cells_eff;
  logic [7:0]    in_ch;

  logic [4:0]    mul_row;
  logic [6:0]    mul_col;
  logic [11:0]   prod;
  logic [AW-1:0] cell_addr, scr_addr, wr_addr, rd_addr;
  logic [15:0]   wr_data;
  logic [SW-1:0] idx_w;
  logic          rd_cell;

  // clamp the programmed geometry into the usable range
  always_comb begin
    if (columns_i == 7'd0) begin
      ncols_eff = 7'd1;
    end else if (int'(columns_i) > MAX_COLS) begin
      ncols_eff = 7'(MAX_COLS);
    end else begin
      ncols_eff = columns_i;
    end
    if (rows_i == 5'd0) begin
      nrows_eff = 5'd1;
    end else if (int'(rows_i) > MAX_ROWS) begin
      nrows_eff = 5'(MAX_ROWS);
    end else begin
      nrows_eff = rows_i;
    end
    cells_eff = 12'({7'd0, nrows_eff} * {5'd0, ncols_eff});
  end

  assign in_ch = in_data_i[9:2];

  // geometry and request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ncols_q <= ncols_eff;
      nrows_q <= nrows_eff;
      cells_q <= cells_eff;
      ch_q    <= (in_ch == CH_TAB) ? CH_SPACE : in_ch;
      rc_q    <= in_data_i[16:10];
      rr_q    <= in_data_i[21:17];
    end
  end

  // cursor and scroll count
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    scroll_d  = scroll_q;
    if (cmd_i.start) begin
      if (cur_row_q > nrows_eff - 5'd1) begin
        cur_row_d = nrows_eff - 5'd1;
      end
      if (cur_col_q > ncols_eff) begin
        cur_col_d = ncols_eff;
      end
    end else begin
      case (cmd_i.cur_op)
        CUR_NEXTROW: begin
          cur_col_d = 7'd0;
          cur_row_d = cur_row_q + 5'd1;
        end
        CUR_SCROLL: begin
          cur_col_d = 7'd0;
          cur_row_d = nrows_q - 5'd1;
          scroll_d  = scroll_q + 32'd1;
        end
        CUR_HOME: begin
          cur_col_d = 7'd0;
          cur_row_d = 5'd0;
          scroll_d  = 32'd0;
        end
        CUR_INC: begin
          cur_col_d = cur_col_q + 7'd1;
        end
        CUR_BACK: begin
          if (cur_col_q == 7'd0) begin
            cur_row_d = cur_row_q - 5'd1;
            cur_col_d = ncols_q - 7'd1;
          end else begin
            cur_col_d = cur_col_q - 7'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= 7'd0;
      cur_row_q   <= 5'd0;
      scroll_q    <= 32'd0;
      idx_q       <= '0;
      put_left_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      scroll_q  <= scroll_d;
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.start) begin
        put_left_q <= (in_ch == CH_TAB) ? 2'd3 : 2'd0;
      end else if (cmd_i.put_dec) begin
        put_left_q <= put_left_q - 2'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // cell address: one shared multiplier for the cursor and the read request
  assign rd_cell   = cmd_i.rd_en && (cmd_i.rd_sel == RD_CELL);
  assign mul_row   = rd_cell ? rr_q : cur_row_q;
  assign mul_col   = rd_cell ? rc_q : cur_col_q;
  assign prod      = 12'({7'd0, mul_row} * {5'd0, ncols_q});
  assign cell_addr = AW'({1'b0, prod} + {6'd0, mul_col});
  assign idx_w     = SW'(idx_q);
  assign scr_addr  = AW'(idx_w + SW'(ncols_q));

  always_comb begin
    case (cmd_i.wr_sel)
      WR_CHAR:      wr_data = {color_i, ch_q};
      WR_BLANK_CUR: wr_data = {color_i, CH_SPACE};
      WR_BLANK_IDX: wr_data = {color_i, CH_SPACE};
      WR_COPY:      wr_data = rdata_q;
      default:      wr_data = CELL_RESET;
    endcase
    if (cmd_i.wr_sel inside {WR_CHAR, WR_BLANK_CUR}) begin
      wr_addr = cell_addr;
    end else begin
      wr_addr = idx_q;
    end
    rd_addr = (cmd_i.rd_sel == RD_CELL) ? cell_addr : scr_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // cell read back and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cell_q <= 16'd0;
    end else if (cmd_i.cell_load) begin
      cell_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_q <= {cell_q[15:8], cell_q[7:0], scroll_q, cur_row_q, cur_col_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'd0, out_q};

  // status toward the controller
  always_comb begin
    sts_o.wrap        = cur_col_q >= ncols_q;
    sts_o.last_row    = cur_row_q >= nrows_q - 5'd1;
    sts_o.col_zero    = cur_col_q == 7'd0;
    sts_o.row_zero    = cur_row_q == 5'd0;
    case (ch_q)
      CH_LF:         sts_o.kind = K_NEWLINE;
      CH_NUL, CH_CR: sts_o.kind = K_IGNORE;
      CH_BS:         sts_o.kind = K_BACKSPACE;
      default:       sts_o.kind = K_PRINT;
    endcase
    sts_o.put_more    = put_left_q != 2'd0;
    sts_o.copy_done   = (idx_w + SW'(ncols_q)) >= SW'(cells_q);
    sts_o.sweep_last  = (idx_w + SW'(1)) == SW'(cells_q);
    sts_o.init_last   = idx_q == AW'(CELLS - 1);
    sts_o.rd_in_range = (rc_q < ncols_q) && (rr_q < nrows_q);
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

endmodule
`default_nettype wire

// File: sv/tcw_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_controller
// Sequencer of the text console writer: puts, tab expansion, scroll and
// clear sweeps, cell reads and the hand-over of each result.
// ----------------------------------------------------------------------------
module tcw_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_op_i,
  input  wire tcw_pkg::sts_t sts_i,
  output logic               in_ready_o,
  output tcw_pkg::cmd_t      cmd_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;
  logic   resume_put_q, resume_put_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      resume_put_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      resume_put_q <= resume_put_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    resume_put_d = resume_put_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.wr_sel = WR_INIT;
    cmd_o.rd_sel = RD_CELL;
    cmd_o.cur_op = CUR_HOLD;

    case (state_q)
      ST_INIT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_INIT;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          case (in_op_i)
            OP_PUT: begin
              state_d = ST_PUT;
            end
            OP_CLEAR: begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_CLR;
            end
            OP_READ: begin
              state_d = ST_RD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_PUT: begin
        if (sts_i.wrap) begin
          // pending wrap first, then the character itself
          if (sts_i.last_row) begin
            cmd_o.idx_clr = 1'b1;
            resume_put_d  = 1'b1;
            state_d       = ST_SCR_RD;
          end else begin
            cmd_o.cur_op = CUR_NEXTROW;
          end
        end else begin
          case (sts_i.kind)
            K_NEWLINE: begin
              if (sts_i.last_row) begin
                cmd_o.idx_clr = 1'b1;
                resume_put_d  = 1'b0;
                state_d       = ST_SCR_RD;
              end else begin
                cmd_o.cur_op  = CUR_NEXTROW;
                cmd_o.put_dec = sts_i.put_more;
                state_d       = sts_i.put_more ? ST_PUT : ST_DONE;
              end
            end
            K_BACKSPACE: begin
              if (sts_i.col_zero && sts_i.row_zero) begin
                cmd_o.put_dec = sts_i.put_more;
                state_d       = sts_i.put_more ? ST_PUT : ST_DONE;
              end else begin
                cmd_o.cur_op = CUR_BACK;
                state_d      = ST_BS_WR;
              end
            end
            K_PRINT: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_CHAR;
              cmd_o.cur_op  = CUR_INC;
              cmd_o.put_dec = sts_i.put_more;
              state_d       = sts_i.put_more ? ST_PUT : ST_DONE;
            end
            default: begin
              cmd_o.put_dec = sts_i.put_more;
              state_d       = sts_i.put_more ? ST_PUT : ST_DONE;
            end
          endcase
        end
      end

      ST_BS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_BLANK_CUR;
        cmd_o.put_dec = sts_i.put_more;
        state_d       = sts_i.put_more ? ST_PUT : ST_DONE;
      end

      ST_SCR_RD: begin
        if (sts_i.copy_done) begin
          state_d = ST_SCR_BL;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SCROLL;
          state_d      = ST_SCR_WR;
        end
      end

      ST_SCR_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_COPY;
        cmd_o.idx_inc = 1'b1;
        state_d       = ST_SCR_RD;
      end

      ST_SCR_BL: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_BLANK_IDX;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.cur_op = CUR_SCROLL;
          if (resume_put_q) begin
            state_d = ST_PUT;
          end else begin
            cmd_o.put_dec = sts_i.put_more;
            state_d       = sts_i.put_more ? ST_PUT : ST_DONE;
          end
        end
      end

      ST_CLR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_BLANK_IDX;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.cur_op = CUR_HOME;
          state_d      = ST_DONE;
        end
      end

      ST_RD: begin
        if (sts_i.rd_in_range) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_CELL;
          state_d      = ST_RD_WAIT;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_RD_WAIT: begin
        cmd_o.cell_load = 1'b1;
        state_d         = ST_DONE;
      end

      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/text_console_writer.sv
`default_nettype none
// Requests are taken only in idle, one at a time; each result goes to the output register
// once that register is free. A pending wrap is resolved before the character; a tab is put
// as four spaces; clear blanks all N = rows * columns cells. A scroll copies the N - C cells
// below the top row up, C = columns in use, and blanks the last row.
// Reset: cursor, scroll count and registers clear at once; the cell memory is then
// swept to blank (space, attribute 0x07), no request taken.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: cell memory with character and attribute, cursor,
// scroll count, configurable geometry and color, and single-cell read back.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned MAX_COLS = 80,
  parameter int unsigned MAX_ROWS = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // request: opcode[1:0], char_code[9:2], read_col[16:10], read_row[21:17]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,

  // result: cursor_col[6:0], cursor_row[11:7], scroll_total[43:12],
  //         cell_char[51:44], cell_attr[59:52]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,

  // register write: 0 columns, 1 rows, 2 color
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);
  import tcw_pkg::*;

  logic [6:0] columns_q;
  logic [4:0] rows_q;
  logic [7:0] color_q;

  cmd_t cmd;
  sts_t sts;

  // Configuration registers; the user must write them only while the engine is idle,
  // which the block does not enforce. The datapath samples the geometry once per request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
      color_q   <= COLOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMNS: columns_q <= cfg_data_i[6:0];
        CFG_ROWS:    rows_q    <= cfg_data_i[4:0];
        CFG_COLOR:   color_q   <= cfg_data_i;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  // Sequencer: one request at a time; hands the result to the output
  // register, which holds it while the next request is taken.
  tcw_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tdata[1:0]),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // Cell memory, cursor, scroll count and result register.
  tcw_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .columns_i   (columns_q),
    .rows_i      (rows_q),
    .color_i     (color_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
